// ===== hdl/ssmm_pkg.sv =====
package ssmm_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned IDX_W  = 6;
    localparam int unsigned LEN_W  = 7;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 3;

    // operation codes carried by an input item
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_TABLE_LENGTH = 1'b0;

    localparam logic [BYTE_W-1:0] DASH_BYTE = 8'h2D;

    typedef struct packed {
        logic wr;    // write one table byte
        logic init;  // load query character, restart walk
        logic step;  // advance the walk
    } t_dp_cmd;

    typedef struct packed {
        logic fin;   // walk ends this cycle
        logic hit;   // character found in this cycle
    } t_dp_stat;

endpackage

// ===== hdl/ssmm_ctrl.sv =====
module ssmm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_operation,
    input  ssmm_pkg::t_dp_stat i_stat,
    output ssmm_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_result_valid,
    output logic              o_matched
);
    import ssmm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_res_vld, n_res_vld;
    logic   r_matched, n_matched;

    always_comb begin
        n_state   = r_state;
        n_res_vld = 1'b0;
        n_matched = r_matched;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_operation == OP_QUERY) begin
                        o_cmd.init = 1'b1;
                        n_state    = S_WALK;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            S_WALK: begin
                o_cmd.step = 1'b1;
                if (i_stat.fin) begin
                    n_res_vld = 1'b1;
                    n_matched = i_stat.hit;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_res_vld <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_matched <= n_matched;
    end

    assign o_busy         = (r_state == S_WALK);
    assign o_result_valid = r_res_vld;
    assign o_matched      = r_matched;

endmodule

// ===== hdl/ssmm_dp.sv =====
module ssmm_dp #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ssmm_pkg::t_dp_cmd             i_cmd,
    input  logic [ssmm_pkg::IDX_W-1:0]    i_table_index,
    input  logic [ssmm_pkg::BYTE_W-1:0]   i_byte_value,
    input  logic [ssmm_pkg::LEN_W-1:0]    i_table_length,
    output ssmm_pkg::t_dp_stat            o_stat
);
    import ssmm_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned LW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned CW = (LW > LEN_W) ? LW : LEN_W;
    localparam int unsigned IW = (AW > IDX_W) ? AW : IDX_W;

    logic [BYTE_W-1:0] r_mem [TABLE_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;
    logic              r_rd_vld, n_rd_vld;
    logic [BYTE_W-1:0] r_ch;
    logic [LW-1:0]     r_rem, n_rem;
    logic [LW-1:0]     r_fcnt, n_fcnt;
    logic [1:0]        r_cnt, n_cnt;
    logic [BYTE_W-1:0] r_win [3];
    logic [BYTE_W-1:0] n_win [3];
    logic [BYTE_W-1:0] ext [4];

    logic [CW-1:0] len_ext;
    logic [LW-1:0] len_sat;
    logic [IW:0]   idx_ext;
    logic          wr_ok;
    logic          fetch;
    logic          rem_ge3;
    logic          ready_eval;
    logic          is_range;
    logic          eval;
    logic          hit;
    logic          take1, take3;
    logic [2:0]    cnt_sum;

    // length saturates at the table depth
    assign len_ext = CW'(i_table_length);
    assign len_sat = (len_ext > CW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : LW'(len_ext);

    // one spare bit so the depth itself fits in the compare
    assign idx_ext = (IW+1)'(i_table_index);
    assign wr_ok   = i_cmd.wr && (idx_ext < (IW+1)'(TABLE_DEPTH));
    assign fetch   = i_cmd.step && (r_fcnt < len_sat);

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[idx_ext[AW-1:0]] <= i_byte_value;
        end
        if (fetch) begin
            r_rd_data <= r_mem[r_fcnt[AW-1:0]];
        end
    end

    // window of up to three bytes, byte at entry start in slot 0
    always_comb begin
        ext[0] = (r_cnt > 2'd0) ? r_win[0] : r_rd_data;
        ext[1] = (r_cnt > 2'd1) ? r_win[1] : r_rd_data;
        ext[2] = (r_cnt > 2'd2) ? r_win[2] : r_rd_data;
        ext[3] = r_rd_data;
    end

    assign rem_ge3    = (r_rem >= LW'(3));
    assign ready_eval = rem_ge3 ? (r_cnt == 2'd3) : (r_cnt != 2'd0);
    assign eval       = i_cmd.step && (r_rem != '0) && ready_eval;
    assign is_range   = rem_ge3 && (r_win[1] == DASH_BYTE);
    assign hit        = eval && (is_range ? ((r_ch >= r_win[0]) && (r_ch <= r_win[2]))
                                          : (r_win[0] == r_ch));
    assign take3      = eval && !hit && is_range;
    assign take1      = eval && !hit && !is_range;

    assign o_stat.hit = hit;
    assign o_stat.fin = i_cmd.step && ((r_rem == '0) || hit);

    always_comb begin
        n_rd_vld = fetch;
        n_fcnt   = r_fcnt + LW'(fetch);
        n_rem    = r_rem;
        cnt_sum  = {1'b0, r_cnt} + {2'b00, r_rd_vld};
        n_win[0] = ext[0];
        n_win[1] = ext[1];
        n_win[2] = ext[2];
        if (take3) begin
            n_rem    = r_rem - LW'(3);
            cnt_sum  = cnt_sum - 3'd3;
            n_win[0] = ext[3];
            n_win[1] = ext[3];
            n_win[2] = ext[3];
        end else if (take1) begin
            n_rem    = r_rem - LW'(1);
            cnt_sum  = cnt_sum - 3'd1;
            n_win[0] = ext[1];
            n_win[1] = ext[2];
            n_win[2] = ext[3];
        end
        n_cnt = cnt_sum[1:0];
        if (!i_cmd.step) begin
            n_rd_vld = r_rd_vld;
            n_cnt    = r_cnt;
        end
        if (i_cmd.init) begin
            n_rd_vld = 1'b0;
            n_cnt    = 2'd0;
            n_fcnt   = '0;
            n_rem    = len_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_cnt    <= 2'd0;
            r_fcnt   <= '0;
            r_rem    <= '0;
        end else begin
            r_rd_vld <= n_rd_vld;
            r_cnt    <= n_cnt;
            r_fcnt   <= n_fcnt;
            r_rem    <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_ch <= i_byte_value;
        end
        if (i_cmd.step) begin
            r_win[0] <= n_win[0];
            r_win[1] <= n_win[1];
            r_win[2] <= n_win[2];
        end
    end

endmodule

// ===== hdl/scanset_membership_matcher_top.sv =====
// channel   | handshake                     | payload
// ----------+-------------------------------+--------------------------------------
// item in   | start, busy (taken: start&!busy) | i_operation, i_table_index, i_byte_value
// result    | o_result_valid, one-cycle strobe | o_matched
// config    | apb write: psel&penable&pwrite   | paddr, pwdata, prdata, pready
//
// a write item is taken at once and busy never rises for it
// a query raises busy while it walks the first L bytes, L = min(table_length, TABLE_DEPTH);
//   an empty table ends the walk at once, and a hit ends it early;
//   the table memory gives one byte per cycle into a three-byte window
// the result strobe shows in the cycle busy falls, and a new item may be taken then
// reset is synchronous and active low; table contents are not cleared
// results cannot be held off by the receiver
module scanset_membership_matcher_top #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item channel
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_operation,
    input  logic [ssmm_pkg::IDX_W-1:0]    i_table_index,
    input  logic [ssmm_pkg::BYTE_W-1:0]   i_byte_value,
    // result channel
    output logic                          o_result_valid,
    output logic                          o_matched,
    // config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ssmm_pkg::ADDR_W-1:0]   paddr,
    input  logic [ssmm_pkg::DATA_W-1:0]   pwdata,
    output logic [ssmm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import ssmm_pkg::*;

    logic [LEN_W-1:0] r_table_length;
    logic             cfg_wr;
    t_dp_cmd          dp_cmd;
    t_dp_stat         dp_stat;

    // config register file: only table_length, at byte address 0
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_length <= '0;
        end else if (cfg_wr && (paddr[2] == REG_TABLE_LENGTH)) begin
            r_table_length <= pwdata[LEN_W-1:0];
        end
    end

    // reads beyond the register list return zero
    assign prdata = (paddr[2] == REG_TABLE_LENGTH) ? DATA_W'(r_table_length) : '0;

    // sequencer: accepts items, runs the walk, posts the result strobe
    ssmm_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_operation    (i_operation),
        .i_stat         (dp_stat),
        .o_cmd          (dp_cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid),
        .o_matched      (o_matched)
    );

    // table memory, streaming fetch and three-byte window matcher
    ssmm_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_table_index  (i_table_index),
        .i_byte_value   (i_byte_value),
        .i_table_length (r_table_length),
        .o_stat         (dp_stat)
    );

endmodule

// ===== hdl/ssmm_checker.sv =====
module ssmm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_operation,
    input logic o_result_valid
);
    import ssmm_pkg::*;

    // a result only ends a walk
    a_result_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result strobe without a preceding walk");

    // end of walk always posts a result
    a_fall_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid)
        else $error("walk ended without a result");

    // a query starts a walk
    a_query_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == OP_QUERY)) |=> busy)
        else $error("query taken but block not busy");

    // a table write finishes in the cycle it is taken
    a_write_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == OP_WRITE)) |=> (!busy && !o_result_valid))
        else $error("table write caused busy or a result");

endmodule

bind scanset_membership_matcher_top ssmm_checker u_ssmm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_operation    (i_operation),
    .o_result_valid (o_result_valid)
);

// ===== tb/scanset_membership_matcher_top_tb.sv =====
`timescale 1ns / 100ps

module scanset_membership_matcher_top_tb;

    import ssmm_pkg::*;

    localparam int unsigned TABLE_DEPTH     = 64;
    // a write item never raises busy, so a short pause covers it
    localparam int unsigned SETTLE_CYCLES   = 8;
    // longest quiet stretch: the longest sender gap plus a full walk
    localparam int unsigned QUIET_LIMIT     = 2000;
    localparam int unsigned PHASES          = 12;
    localparam int unsigned ITEMS_PER_PHASE = 52;
    localparam int unsigned TRIPLE_LEN      = 3;
    localparam logic [ADDR_W-1:0] TABLE_LENGTH_ADDR = {REG_TABLE_LENGTH, 2'b00};

    // one outstanding query: the character asked and the flag it should get
    typedef struct {
        logic [BYTE_W-1:0] ch;
        logic              matched;
    } t_membership;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                start         = 1'b0;
    logic                busy;
    logic                i_operation   = OP_WRITE;
    logic [IDX_W-1:0]    i_table_index = '0;
    logic [BYTE_W-1:0]   i_byte_value  = '0;
    logic                o_result_valid;
    logic                o_matched;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [ADDR_W-1:0]   paddr         = '0;
    logic [DATA_W-1:0]   pwdata        = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // shadow of the block: table bytes and the length register
    logic [BYTE_W-1:0]   scanset_shadow [TABLE_DEPTH];
    logic [LEN_W-1:0]    length_shadow = '0;

    t_membership         expected_answers [$];
    int unsigned         mismatch_count = 0;
    int unsigned         quiet_cycles   = 0;

    scanset_membership_matcher_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_table_index  (i_table_index),
        .i_byte_value   (i_byte_value),
        .o_result_valid (o_result_valid),
        .o_matched      (o_matched),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t ERROR %s", $time, what);
    endtask

    // walk the shadow table the way a scanset is matched
    function automatic logic scanset_contains(input logic [BYTE_W-1:0] ch);
        int unsigned pos;
        int unsigned left;
        pos  = 0;
        left = (length_shadow > TABLE_DEPTH) ? TABLE_DEPTH : length_shadow;
        // range triple lo '-' hi while a full window remains
        while (left >= TRIPLE_LEN) begin
            if (scanset_shadow[pos+1] == DASH_BYTE) begin
                if (ch >= scanset_shadow[pos] && ch <= scanset_shadow[pos+2])
                    return 1'b1;
                pos  += TRIPLE_LEN;
                left -= TRIPLE_LEN;
            end else begin
                if (scanset_shadow[pos] == ch)
                    return 1'b1;
                pos++;
                left--;
            end
        end
        // short tail: literals only, a dash here is just a dash
        while (left != 0) begin
            if (scanset_shadow[pos] == ch)
                return 1'b1;
            pos++;
            left--;
        end
        return 1'b0;
    endfunction

    // mostly back to back, often a short gap, now and then a long pause
    function automatic int unsigned pick_gap(input bit back_to_back);
        int unsigned r;
        if (back_to_back)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // table bytes lean toward dashes and letters so ranges form often
    function automatic logic [BYTE_W-1:0] random_table_byte();
        int unsigned r;
        logic [BYTE_W-1:0] b;
        r = $urandom_range(0, 9);
        if (r < 3)
            b = DASH_BYTE;
        else if (r < 6)
            b = BYTE_W'($urandom_range(8'h61, 8'h7A));
        else
            b = BYTE_W'($urandom_range(0, 255));
        return b;
    endfunction

    // half the characters sit on or next to a byte in the active table
    function automatic logic [BYTE_W-1:0] query_char();
        int unsigned span;
        logic [BYTE_W-1:0] pivot;
        span = (length_shadow > TABLE_DEPTH) ? TABLE_DEPTH : length_shadow;
        if (span == 0 || $urandom_range(0, 1) == 0) begin
            pivot = BYTE_W'($urandom_range(0, 255));
            return pivot;
        end
        pivot = scanset_shadow[$urandom_range(0, span - 1)];
        case ($urandom_range(0, 2))
            0: return pivot - 8'd1;
            1: return pivot;
            default: return pivot + 8'd1;
        endcase
    endfunction

    // start stays high after an item is taken when the next follows at once;
    // it drops only when a gap comes or the sender goes idle
    task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                             input logic [BYTE_W-1:0] value, input int unsigned gap);
        t_membership answer;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_operation   <= op;
        i_table_index <= idx;
        i_byte_value  <= value;
        do @(posedge i_clk); while (busy);
        // item taken at this edge
        if (op == OP_WRITE) begin
            scanset_shadow[idx] = value;
        end else begin
            answer.ch      = value;
            answer.matched = scanset_contains(value);
            expected_answers.push_back(answer);
        end
    endtask

    // drop start, let every query answer, then let a last write settle
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write the length register, then read it back in the next transfer
    task automatic set_table_length(input logic [LEN_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TABLE_LENGTH_ADDR;
        pwdata  <= {{(DATA_W-LEN_W){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        length_shadow = value;
        // read setup follows the write access directly
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {{(DATA_W-LEN_W){1'b0}}, length_shadow})
            report_mismatch($sformatf("table_length read 0x%08h, want 0x%08h",
                                      prdata, {{(DATA_W-LEN_W){1'b0}}, length_shadow}));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // load a small scanset "a-z _ 00 ff -", query with the reset length of zero
    task automatic test_reset_length_empty();
        logic [BYTE_W-1:0] scanset_bytes [7];
        scanset_bytes = '{8'h61, DASH_BYTE, 8'h7A, 8'h5F, 8'h00, 8'hFF, DASH_BYTE};
        for (int i = 0; i < 7; i++)
            send_item(OP_WRITE, IDX_W'(i), scanset_bytes[i], pick_gap(1'b0));
        // empty table never matches
        send_item(OP_QUERY, 6'h3F, 8'h61, pick_gap(1'b0));
        send_item(OP_QUERY, 6'h00, 8'h00, pick_gap(1'b0));
        wait_idle();
    endtask

    // range bounds, just outside them, literals, a trailing dash as literal
    task automatic test_ranges_and_literals();
        logic [BYTE_W-1:0] probes [10];
        probes = '{8'h61, 8'h7A, 8'h6D, 8'h60, 8'h7B, 8'h5F, 8'h00, 8'hFF, DASH_BYTE, 8'h41};
        set_table_length(7'd7);
        for (int i = 0; i < 10; i++)
            send_item(OP_QUERY, IDX_W'($urandom_range(0, 63)), probes[i], pick_gap(1'b0));
        wait_idle();
    endtask

    // two bytes "a-" must stay literals, so 'b' misses
    task automatic test_short_tail();
        set_table_length(7'd2);
        send_item(OP_QUERY, 6'h15, DASH_BYTE, pick_gap(1'b0));
        send_item(OP_QUERY, 6'h2A, 8'h61, pick_gap(1'b0));
        send_item(OP_QUERY, 6'h00, 8'h62, pick_gap(1'b0));
        wait_idle();
    endtask

    // fill the whole table, then phases at many lengths mixing queries and rewrites
    task automatic test_random_scansets();
        logic [LEN_W-1:0] lengths [PHASES];
        bit back_to_back;
        lengths = '{7'd64, 7'd127, 7'd0, 7'd1, 7'd2, 7'd3, 7'd65, 7'd100,
                    7'd5, 7'd9, 7'd17, 7'd40};
        for (int p = 8; p < PHASES; p++)
            lengths[p] = LEN_W'($urandom_range(4, 127));
        // every entry written before any walk can reach it
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_item(OP_WRITE, IDX_W'(i), random_table_byte(), pick_gap(1'b0));
        wait_idle();
        for (int p = 0; p < PHASES; p++) begin
            set_table_length(lengths[p]);
            // every fourth phase runs with no gaps at all
            back_to_back = (p % 4 == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 4) == 0)
                    send_item(OP_WRITE, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                              random_table_byte(), pick_gap(back_to_back));
                else
                    send_item(OP_QUERY, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                              query_char(), pick_gap(back_to_back));
            end
            wait_idle();
        end
    endtask

    // each strobe is compared with the oldest outstanding query
    always @(posedge i_clk) begin : check_results
        t_membership answer;
        if (i_rst_n && o_result_valid) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("result strobe with no query outstanding");
            end else begin
                answer = expected_answers.pop_front();
                if (o_matched !== answer.matched)
                    report_mismatch($sformatf("matched for char 0x%02h: got %b, want %b",
                                              answer.ch, o_matched, answer.matched));
            end
        end
    end

    // watchdog: any item, result or register transfer counts as progress
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("scanset_membership_matcher_top_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_length_empty();
        test_ranges_and_literals();
        test_short_tail();
        test_random_scansets();
        wait_idle();
        if (mismatch_count == 0)
            $display("scanset_membership_matcher_top_tb: done, clean");
        else
            $display("scanset_membership_matcher_top_tb: done, errors");
        $finish;
    end

endmodule
